FILE: hdl/sve_pkg.sv
// Shared types and constants for the signed varint encoder.
// No dependencies; used by sve_ctrl, sve_dp and signed_varint_encoder.
`default_nettype none

package sve_pkg;

  // Input command codes
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam int VALUE_W   = 32;
  localparam int MAPPED_W  = VALUE_W + 1;  // most negative input maps to 2^32+1
  localparam int GROUP_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 5;
  localparam int CNT_W     = $clog2(MAX_BYTES);

  localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7F;
  localparam logic [BYTE_W-1:0]  CONT_BIT   = 8'h80;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture mapped input value
    logic emit;  // load output byte, shift value down one group
    logic last;  // byte being emitted is the final one
  } sve_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic value_zero;  // input value is the terminator
    logic rest_zero;   // no set bits above the current group
  } sve_stat_t;

endpackage

`default_nettype wire

FILE: hdl/sve_dp.sv
// Datapath of the signed varint encoder: sign mapping, group shifter, output byte.
// Depends on sve_pkg.
`default_nettype none

module sve_dp (
  input  wire                                clk,
  input  wire logic signed [sve_pkg::VALUE_W-1:0] in_value,
  input  wire sve_pkg::sve_cmd_t             cmd,
  output sve_pkg::sve_stat_t                 stat,
  output logic [sve_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last
);

  logic [sve_pkg::MAPPED_W-1:0] val_r, val_nxt;
  logic [sve_pkg::MAPPED_W-1:0] mapped;
  logic [sve_pkg::MAPPED_W-1:0] magnitude;
  logic [sve_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  logic                         last_r, last_nxt;

  // Negative x maps to 2|x|+1, others to 2x; width holds the most negative input
  always_comb begin
    magnitude = sve_pkg::MAPPED_W'(0) - {in_value[sve_pkg::VALUE_W-1], in_value};
    if (in_value[sve_pkg::VALUE_W-1]) begin
      mapped = {magnitude[sve_pkg::VALUE_W-1:0], 1'b1};
    end else begin
      mapped = {in_value[sve_pkg::VALUE_W-1:0], 1'b0};
    end
  end

  always_comb begin
    val_nxt  = val_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (cmd.load) begin
      val_nxt = mapped;
    end else if (cmd.emit) begin
      val_nxt  = val_r >> sve_pkg::GROUP_W;
      byte_nxt = (cmd.last ? '0 : sve_pkg::CONT_BIT)
               | {1'b0, val_r[sve_pkg::GROUP_W-1:0] & sve_pkg::GROUP_MASK};
      last_nxt = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign stat.value_zero = (in_value == '0);
  assign stat.rest_zero  = (val_r[sve_pkg::MAPPED_W-1:sve_pkg::GROUP_W] == '0);
  assign out_byte        = byte_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

FILE: hdl/sve_ctrl.sv
// Controller of the signed varint encoder: handshakes, terminator flag, byte count.
// Depends on sve_pkg.
`default_nettype none

module sve_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       in_command,
  output logic                      out_valid,
  input  wire                       out_ready,
  input  wire sve_pkg::sve_stat_t   stat,
  output sve_pkg::sve_cmd_t         cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [sve_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      term_r, term_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      in_fire;
  logic                      slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_command == sve_pkg::CMD_RESTART) begin
            term_nxt = 1'b0;
          end else begin
            // drop the word while terminated, but still track the terminator
            term_nxt = stat.value_zero;
            if (!term_r) begin
              cmd.load  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.last      = stat.rest_zero
                       || (cnt_r == sve_pkg::CNT_W'(sve_pkg::MAX_BYTES - 1));
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sve_pkg::CNT_W'(sve_pkg::MAX_BYTES))
    else $error("byte count past maximum");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("output byte overwritten before taken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == ST_IDLE))
    else $error("emit continued after final byte");

  a_terminated_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && term_r) |-> !cmd.load)
    else $error("word encoded while terminated");
`endif

endmodule

`default_nettype wire

FILE: hdl/signed_varint_encoder.sv
// Top level of the signed varint encoder: zigzag-style mapping plus 7-bit group output.
// Depends on sve_pkg, sve_ctrl and sve_dp.
//
//   channel  ports                                   direction  word
//   in       in_valid/in_ready, in_command, in_value input      one command or value
//   out      out_valid/out_ready, out_byte, out_last output     one encoded byte
//
// An add is accepted, then produces one output byte per 7-bit group (1 to 5),
// set by the group shifter that emits a single 7-bit group per cycle while out_ready allows.
// A restart, or an add while the terminator flag is set, is accepted and
// produces no byte.
// The final byte sits in the output register while the next word is accepted.
// A stalled out_ready holds the shifter; reset clears the flag and the output.
`default_nettype none

module signed_varint_encoder (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire                                      in_command,
  input  wire logic signed [sve_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic [sve_pkg::BYTE_W-1:0]               out_byte,
  output logic                                     out_last
);

  sve_pkg::sve_cmd_t  cmd;
  sve_pkg::sve_stat_t stat;

  // Controller: handshakes, terminator flag and byte count
  sve_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: map the value, shift out groups, hold the output byte
  sve_dp u_dp (
    .clk      (clk),
    .in_value (in_value),
    .cmd      (cmd),
    .stat     (stat),
    .out_byte (out_byte),
    .out_last (out_last)
  );

`ifndef NO_ASSERTIONS
  a_cont_on_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_byte[sve_pkg::BYTE_W-1])
    else $error("continuation bit missing on inner byte");

  a_no_cont_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !out_byte[sve_pkg::BYTE_W-1])
    else $error("continuation bit set on final byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !in_ready) |-> !$past(cmd.emit && cmd.last))
    else $error("not ready after final byte emitted");
`endif

endmodule

`default_nettype wire
